// ----- rtl/wpnm_pkg.sv -----
// Pedestal noise monitor package: payload structs, register codes, fixed widths.
// No dependencies; used by the top level.
`default_nettype none

package wpnm_pkg;

    localparam int ADC_BITS    = 14;
    localparam int SLOT_W      = 3;
    localparam int CHAN_W      = 8;
    localparam int WSUM_W      = 19;
    localparam int CNT_W       = 16;
    localparam int SCOUNT_W    = 6;
    localparam int THR_W       = 14;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SCOUNT_W-1:0] SCOUNT_RST   = 6'd16;
    localparam logic [THR_W-1:0]    MEAN_THR_RST = 14'd16383;
    localparam logic [THR_W-1:0]    RMS_THR_RST  = 14'd16383;
    localparam logic [CNT_W-1:0]    HOT_THR_RST  = 16'd65535;

    typedef enum logic [1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_MEAN_THR     = 2'd1,
        CFG_RMS_THR      = 2'd2,
        CFG_HOT_THR      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SLOT_W-1:0]   packet_slot;
        logic [CHAN_W-1:0]   channel;
        logic [ADC_BITS-1:0] adc_sample;
        logic                packet_ok;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] out_slot;
        logic [CHAN_W-1:0] out_channel;
        logic [WSUM_W-1:0] waveform_sum;
        logic              is_bad;
        logic [CNT_W-1:0]  bad_count;
        logic              is_hot;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/wpnm_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read during a write to the same address returns the old contents.
`default_nettype none

module wpnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/waveform_pedestal_noise_monitor_unit.sv -----
// Pedestal mean/RMS monitor: takes one ADC sample per transfer and, at the end of
// each waveform, checks mean and RMS against thresholds and counts bad events per
// (slot, channel). One sample is taken every cycle while the result side keeps up;
// a waveform's result passes through stages 1 to 3 and then the output register.
// After reset the counter RAM is zeroed, one entry per cycle, all PACKETS*CHANNELS
// entries (1536 at the defaults), while input is stalled. The counter update is a RAM
// read-modify-write with one-entry forwarding, so results for the same channel may
// follow back to back. Depends on wpnm_pkg and wpnm_ram.
`default_nettype none

module waveform_pedestal_noise_monitor_unit #(
    parameter int PACKETS     = 8,
    parameter int CHANNELS    = 192,
    parameter int MAX_SAMPLES = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire wpnm_pkg::t_cfg_idx             i_cfg_idx,
    input  wire logic [wpnm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire wpnm_pkg::t_in_item             i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output wpnm_pkg::t_out_item                 o_out
);

    import wpnm_pkg::*;

    localparam int DEPTH = PACKETS * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(MAX_SAMPLES + 1);   // holds n up to MAX_SAMPLES
    localparam int SW    = NW + ADC_BITS;             // sum of samples, also n*threshold
    localparam int SQ_W  = 2 * ADC_BITS;
    localparam int QW    = NW + SQ_W;                 // sum of squares
    localparam int DW    = 2 * SW;                    // n*sumsq, sum^2, (n*rms)^2
    localparam int CMPW  = (NW > SCOUNT_W) ? NW : SCOUNT_W;

    // configuration
    logic [SCOUNT_W-1:0] r_sample_count;
    logic [THR_W-1:0]    r_mean_thr;
    logic [THR_W-1:0]    r_rms_thr;
    logic [CNT_W-1:0]    r_hot_thr;

    // accumulators
    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_sq;
    logic [NW-1:0] r_idx;

    // clear pass
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    // stage 1: finished waveform
    logic              r_s1_vld;
    logic [SLOT_W-1:0] r_s1_slot;
    logic [CHAN_W-1:0] r_s1_chan;
    logic [SW-1:0]     r_s1_sum;
    logic [QW-1:0]     r_s1_sq;
    logic [NW-1:0]     r_s1_n;

    // stage 2: products
    logic              r_s2_vld;
    logic [SLOT_W-1:0] r_s2_slot;
    logic [CHAN_W-1:0] r_s2_chan;
    logic [SW-1:0]     r_s2_sum;
    logic              r_s2_inr;
    logic [AW-1:0]     r_s2_addr;
    logic [DW-1:0]     r_s2_nsq;
    logic [DW-1:0]     r_s2_ssq;
    logic [SW-1:0]     r_s2_nrms;
    logic              r_s2_mean_bad;

    // stage 3: variance and threshold, counter read data arrives
    logic              r_s3_vld;
    logic [SLOT_W-1:0] r_s3_slot;
    logic [CHAN_W-1:0] r_s3_chan;
    logic [SW-1:0]     r_s3_sum;
    logic              r_s3_inr;
    logic [AW-1:0]     r_s3_addr;
    logic [DW-1:0]     r_s3_diff;
    logic [DW-1:0]     r_s3_thr;
    logic              r_s3_mean_bad;

    // last counter write, for forwarding into a read issued on the same edge
    logic              r_lw_vld;
    logic [AW-1:0]     r_lw_addr;
    logic [CNT_W-1:0]  r_lw_data;

    logic              r_out_vld;
    t_out_item         r_out;

    logic              adv;
    logic              acc;
    logic              take;
    logic [NW-1:0]     n_eff;
    logic              last;
    logic [SW-1:0]     n_sum;
    logic [QW-1:0]     n_sq;
    logic              s1_inr;
    logic [AW-1:0]     s1_addr;
    logic [CNT_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  cnt_old;
    logic [CNT_W-1:0]  cnt_new;
    logic              s3_bad;
    logic              s3_hot;
    logic              s3_we;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;

    // whole pipeline steps together whenever the output register can take a result
    assign adv        = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_clr || !adv;
    assign acc        = i_in_valid && !o_in_stall;
    assign take       = acc && i_in.packet_ok;

    always_comb begin
        if (r_sample_count == '0) begin
            n_eff = NW'(1);
        end else if (CMPW'(r_sample_count) > CMPW'(MAX_SAMPLES)) begin
            n_eff = NW'(MAX_SAMPLES);
        end else begin
            n_eff = NW'(r_sample_count);
        end
    end

    assign last  = ({1'b0, r_idx} + (NW + 1)'(1)) >= {1'b0, n_eff};
    assign n_sum = r_sum + SW'(i_in.adc_sample);
    assign n_sq  = r_sq + QW'(SQ_W'(i_in.adc_sample) * SQ_W'(i_in.adc_sample));

    assign s1_inr  = (int'(r_s1_slot) < PACKETS) && (int'(r_s1_chan) < CHANNELS);
    assign s1_addr = AW'(int'(r_s1_slot) * CHANNELS + int'(r_s1_chan));

    assign cnt_old = (r_lw_vld && (r_lw_addr == r_s3_addr)) ? r_lw_data : ram_rdata;
    assign s3_bad  = r_s3_mean_bad || (r_s3_diff >= r_s3_thr);
    assign cnt_new = (s3_bad && (cnt_old != '1)) ? cnt_old + CNT_W'(1) : cnt_old;
    assign s3_hot  = cnt_new >= r_hot_thr;
    assign s3_we   = adv && r_s3_vld && r_s3_inr;

    assign ram_we    = r_clr || s3_we;
    assign ram_waddr = r_clr ? r_clr_addr : r_s3_addr;
    assign ram_wdata = r_clr ? '0 : cnt_new;

    wpnm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (r_s2_addr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SCOUNT_RST;
            r_mean_thr     <= MEAN_THR_RST;
            r_rms_thr      <= RMS_THR_RST;
            r_hot_thr      <= HOT_THR_RST;
            r_sum          <= '0;
            r_sq           <= '0;
            r_idx          <= '0;
            r_clr          <= 1'b1;
            r_clr_addr     <= '0;
            r_s1_vld       <= 1'b0;
            r_s2_vld       <= 1'b0;
            r_s3_vld       <= 1'b0;
            r_lw_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[SCOUNT_W-1:0];
                    CFG_MEAN_THR:     r_mean_thr     <= i_cfg_data[THR_W-1:0];
                    CFG_RMS_THR:      r_rms_thr      <= i_cfg_data[THR_W-1:0];
                    CFG_HOT_THR:      r_hot_thr      <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (take) begin
                if (last) begin
                    r_sum <= '0;
                    r_sq  <= '0;
                    r_idx <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_sq  <= n_sq;
                    r_idx <= r_idx + NW'(1);
                end
            end
            if (adv) begin
                r_s1_vld  <= take && last;
                r_s2_vld  <= r_s1_vld;
                r_s3_vld  <= r_s2_vld;
                r_lw_vld  <= s3_we;
                r_out_vld <= r_s3_vld;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (take && last) begin
                r_s1_slot <= i_in.packet_slot;
                r_s1_chan <= i_in.channel;
                r_s1_sum  <= n_sum;
                r_s1_sq   <= n_sq;
                r_s1_n    <= n_eff;
            end
            r_s2_slot     <= r_s1_slot;
            r_s2_chan     <= r_s1_chan;
            r_s2_sum      <= r_s1_sum;
            r_s2_inr      <= s1_inr;
            r_s2_addr     <= s1_addr;
            r_s2_nsq      <= DW'(r_s1_n) * DW'(r_s1_sq);
            r_s2_ssq      <= DW'(r_s1_sum) * DW'(r_s1_sum);
            r_s2_nrms     <= SW'(r_s1_n) * SW'(r_rms_thr);
            r_s2_mean_bad <= r_s1_sum > (SW'(r_s1_n) * SW'(r_mean_thr));

            r_s3_slot     <= r_s2_slot;
            r_s3_chan     <= r_s2_chan;
            r_s3_sum      <= r_s2_sum;
            r_s3_inr      <= r_s2_inr;
            r_s3_addr     <= r_s2_addr;
            r_s3_diff     <= r_s2_nsq - r_s2_ssq;
            r_s3_thr      <= DW'(r_s2_nrms) * DW'(r_s2_nrms);
            r_s3_mean_bad <= r_s2_mean_bad;

            r_lw_addr <= r_s3_addr;
            r_lw_data <= cnt_new;

            if (r_s3_vld) begin
                r_out.out_slot     <= r_s3_slot;
                r_out.out_channel  <= r_s3_chan;
                r_out.waveform_sum <= WSUM_W'(r_s3_sum);
                r_out.is_bad       <= s3_bad;
                r_out.bad_count    <= r_s3_inr ? cnt_new : '0;
                r_out.is_hot       <= r_s3_inr && s3_hot;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // no waveform in flight while the counter RAM is being zeroed
    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !(r_s1_vld || r_s2_vld || r_s3_vld || r_out_vld))
        else $error("pipeline busy during counter clear");

    // clear pass covers the whole RAM before it ends
    a_clr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr) |-> $past(r_clr_addr) == AW'(DEPTH - 1))
        else $error("counter clear ended early");

    // accumulators restart after the last sample of a waveform
    a_acc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && last) |=> (r_idx == '0 && r_sum == '0 && r_sq == '0))
        else $error("accumulators not cleared at end of waveform");

endmodule

`default_nettype wire

// ----- test/waveform_pedestal_noise_monitor_unit_test.sv -----
// Self-checking bench for waveform_pedestal_noise_monitor_unit: directed and random ADC
// sample streams, predicted per transfer by a behavioral mean/RMS/bad-count model.
// Depends on wpnm_pkg and the unit RTL.
`timescale 1ns / 100ps
`default_nettype none

module waveform_pedestal_noise_monitor_unit_test;
    import wpnm_pkg::*;

    localparam int PACKETS          = 8;
    localparam int CHANNELS         = 192;
    localparam int MAX_SAMPLES      = 32;
    localparam int STORE_DEPTH      = PACKETS * CHANNELS;
    localparam int ADC_MAX          = (1 << ADC_BITS) - 1;
    localparam int IN_W             = $bits(t_in_item);
    localparam logic [CNT_W-1:0] COUNT_FULL = '1;
    localparam int SETTLE_CYCLES    = 10;
    localparam int SQUEEZE_CYCLES   = 400;
    localparam int RANDOM_SAMPLES   = 1500;
    localparam int PHASE_SAMPLES    = 220;
    localparam int PRINT_CAP        = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_idx = CFG_SAMPLE_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out;

    // mirrored registers
    logic [SCOUNT_W-1:0] cfg_samples  = SCOUNT_RST;
    logic [THR_W-1:0]    cfg_mean_thr = MEAN_THR_RST;
    logic [THR_W-1:0]    cfg_rms_thr  = RMS_THR_RST;
    logic [CNT_W-1:0]    cfg_hot_thr  = HOT_THR_RST;

    // mirrored accumulators and bad-event counts
    longint unsigned     run_sum = 0;
    longint unsigned     run_sq = 0;
    int unsigned         taken = 0;
    logic [CNT_W-1:0]    bad_counts [STORE_DEPTH] = '{default: '0};

    t_in_item            pending_samples[$];
    t_out_item           expected_results[$];
    int unsigned         mismatches = 0;
    int unsigned         results_seen = 0;
    int unsigned         good_queued = 0;
    bit                  calm = 1'b0;
    bit                  squeeze_done = 1'b0;
    int unsigned         squeeze_left = 0;

    always #6 i_clk = ~i_clk;

    waveform_pedestal_noise_monitor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    function automatic int unsigned samples_per_wave();
        int unsigned n;
        n = 32'(cfg_samples);
        if (n == 0) n = 1;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        return n;
    endfunction

    // Accumulate one sample; returns 1 with the waveform verdict when it closes a waveform.
    function automatic bit waveform_check(input t_in_item s, output t_out_item res);
        longint unsigned n;
        longint unsigned spread_n2;
        longint unsigned limit_n2;
        longint unsigned adc;
        int unsigned     addr;
        logic [CNT_W-1:0] cnt;
        bit              bad;
        bit              hot;
        res = '0;
        if (!s.packet_ok) return 1'b0;
        adc = 64'(s.adc_sample);
        run_sum += adc;
        run_sq += adc * adc;
        taken++;
        n = 64'(samples_per_wave());
        if (taken < n) return 1'b0;
        // n*sumsq - sum^2 is n^2 times the population variance, never negative
        spread_n2 = n * run_sq - run_sum * run_sum;
        limit_n2 = (n * cfg_rms_thr) * (n * cfg_rms_thr);
        bad = (run_sum > n * cfg_mean_thr) || (spread_n2 >= limit_n2);
        cnt = '0;
        hot = 1'b0;
        if (s.packet_slot < PACKETS && s.channel < CHANNELS) begin
            addr = 32'(int'(s.packet_slot) * CHANNELS + int'(s.channel));
            cnt = bad_counts[addr];
            if (bad && cnt != COUNT_FULL) cnt++;
            bad_counts[addr] = cnt;
            hot = cnt >= cfg_hot_thr;
        end
        res.out_slot = s.packet_slot;
        res.out_channel = s.channel;
        res.waveform_sum = run_sum[WSUM_W-1:0];
        res.is_bad = bad;
        res.bad_count = cnt;
        res.is_hot = hot;
        run_sum = 0;
        run_sq = 0;
        taken = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // sender side: predict on each accepted transfer, then offer the next sample
    always @(posedge i_clk) begin : drive
        t_out_item res;
        if (i_in_valid && !o_in_stall && waveform_check(i_in, res))
            expected_results.insert(expected_results.size(), res);
        if (!(i_in_valid && o_in_stall)) begin
            if (pending_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
                i_in <= pending_samples.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver side: check each transfer, stall at random, hold off once for a long stretch
    always @(posedge i_clk) begin : receive
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(o_out), '0);
            end else begin
                want = expected_results.pop_front();
                check_field("out_slot", 64'(o_out.out_slot), 64'(want.out_slot));
                check_field("out_channel", 64'(o_out.out_channel), 64'(want.out_channel));
                check_field("waveform_sum", 64'(o_out.waveform_sum),
                            64'(want.waveform_sum));
                check_field("is_bad", 64'(o_out.is_bad), 64'(want.is_bad));
                check_field("bad_count", 64'(o_out.bad_count), 64'(want.bad_count));
                check_field("is_hot", 64'(o_out.is_hot), 64'(want.is_hot));
            end
        end
        if (!squeeze_done && results_seen >= 60 && pending_samples.size() > 200) begin
            squeeze_done = 1'b1;
            squeeze_left = SQUEEZE_CYCLES;
        end
        if (squeeze_left != 0) begin
            squeeze_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && $urandom_range(0, 99) < 10;
        end
    end

    function automatic logic [ADC_BITS-1:0] clamp_adc(int v);
        if (v < 0) return '0;
        if (v > ADC_MAX) return ADC_BITS'(ADC_MAX);
        return v[ADC_BITS-1:0];
    endfunction

    task automatic add_sample(logic [SLOT_W-1:0] slot, logic [CHAN_W-1:0] chan,
                              logic [ADC_BITS-1:0] adc, logic ok);
        t_in_item s;
        s.packet_slot = slot;
        s.channel = chan;
        s.adc_sample = adc;
        s.packet_ok = ok;
        pending_samples.insert(pending_samples.size(), s);
        if (ok) good_queued++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SAMPLE_COUNT: cfg_samples = data[SCOUNT_W-1:0];
            CFG_MEAN_THR:     cfg_mean_thr = data[THR_W-1:0];
            CFG_RMS_THR:      cfg_rms_thr = data[THR_W-1:0];
            CFG_HOT_THR:      cfg_hot_thr = data[CNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] n, logic [CFG_DATA_W-1:0] mean,
                             logic [CFG_DATA_W-1:0] rms, logic [CFG_DATA_W-1:0] hot);
        write_reg(CFG_SAMPLE_COUNT, n);
        write_reg(CFG_MEAN_THR, mean);
        write_reg(CFG_RMS_THR, rms);
        write_reg(CFG_HOT_THR, hot);
    endtask

    // let everything queued go through and all results come back, then let the pipe empty
    task automatic drain_and_settle();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Waveform of len samples around a level mostly near the mean threshold; failed-packet noise
    // is mixed in, and some waveforms carry different tags on every sample.
    task automatic add_waveform(int unsigned len);
        int               center;
        int               spread;
        bit               mixed;
        t_in_item         junk;
        logic [SLOT_W-1:0] slot;
        logic [CHAN_W-1:0] chan;
        case ($urandom_range(0, 3))
            0: center = int'(cfg_mean_thr);
            1: center = int'($urandom_range(0, ADC_MAX));
            default: center = int'(clamp_adc(int'(cfg_mean_thr) +
                                              int'($urandom_range(0, 400)) - 200));
        endcase
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = int'(cfg_rms_thr);
            default: spread = int'($urandom_range(0, 2 * cfg_rms_thr + 2));
        endcase
        mixed = $urandom_range(0, 9) == 0;
        slot = SLOT_W'($urandom_range(0, 7));
        chan = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, 255))
                                           : CHAN_W'($urandom_range(0, 3));
        repeat (len) begin
            if ($urandom_range(0, 99) < 8) begin
                junk = IN_W'($urandom);
                junk.packet_ok = 1'b0;
                pending_samples.insert(pending_samples.size(), junk);
            end
            if (mixed) begin
                slot = SLOT_W'($urandom_range(0, 7));
                chan = CHAN_W'($urandom_range(0, 255));
            end
            add_sample(slot, chan,
                       clamp_adc(center + int'($urandom_range(0, 2 * spread)) - spread), 1'b1);
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned phase_start;
        int unsigned random_start;
        logic [CFG_DATA_W-1:0] n_data;
        logic [CFG_DATA_W-1:0] rms_data;
        logic [CFG_DATA_W-1:0] hot_data;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: a failed packet with every field high, then a full-scale flat
        // waveform at the last valid address (mean exactly at threshold)
        add_sample(3'd7, 8'd255, ADC_BITS'(ADC_MAX), 1'b0);
        repeat (16) add_sample(3'd7, 8'd191, ADC_BITS'(ADC_MAX), 1'b1);
        drain_and_settle();

        // count of zero acts as one; zero mean and RMS thresholds with a hot threshold of one
        // make everything bad, and hot except at an address outside the store
        configure(16'd0, 16'd0, 16'd0, 16'd1);
        add_sample(3'd0, 8'd0, ADC_BITS'(0), 1'b1);
        add_sample(3'd7, 8'd255, ADC_BITS'(ADC_MAX), 1'b1);
        add_sample(3'd0, 8'd0, ADC_BITS'(0), 1'b1);
        drain_and_settle();

        // shrink the count under a half-taken waveform: the next sample closes it
        write_reg(CFG_SAMPLE_COUNT, 16'd4);
        add_sample(3'd3, 8'd10, ADC_BITS'(100), 1'b1);
        add_sample(3'd3, 8'd10, ADC_BITS'(9000), 1'b1);
        add_sample(3'd3, 8'd11, ADC_BITS'(16000), 1'b1);
        drain_and_settle();
        write_reg(CFG_SAMPLE_COUNT, 16'd2);
        add_sample(3'd4, 8'd20, ADC_BITS'(1), 1'b1);
        drain_and_settle();

        random_start = good_queued;
        phase = 0;
        while (good_queued - random_start < RANDOM_SAMPLES) begin
            case (phase)
                0: configure({10'($urandom), 6'd63}, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: configure(16'd0, 16'd0, 16'd0, 16'd0);
                default: begin
                    case ($urandom_range(0, 9))
                        0: n_data = ($urandom_range(0, 1) == 0) ? 16'd0
                                                                : 16'($urandom_range(33, 63));
                        1, 2: n_data = 16'($urandom_range(7, 32));
                        default: n_data = 16'($urandom_range(1, 6));
                    endcase
                    n_data[CFG_DATA_W-1:SCOUNT_W] = (CFG_DATA_W - SCOUNT_W)'($urandom);
                    rms_data = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 300))
                                                            : 16'($urandom_range(0, 65535));
                    case ($urandom_range(0, 5))
                        0: hot_data = 16'd0;
                        1: hot_data = 16'hFFFF;
                        2: hot_data = 16'($urandom_range(0, 65535));
                        default: hot_data = 16'($urandom_range(1, 6));
                    endcase
                    configure(n_data, 16'($urandom_range(0, 65535)), rms_data, hot_data);
                end
            endcase
            calm = phase == 2;
            phase_start = good_queued;
            while (good_queued - phase_start < PHASE_SAMPLES)
                add_waveform(samples_per_wave());
            // sometimes leave a partial waveform for the next setting to finish
            if ($urandom_range(0, 1) == 0)
                add_waveform($urandom_range(0, samples_per_wave() - 1));
            drain_and_settle();
            calm = 1'b0;
            phase++;
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
